FILE: rtl/xsr_pkg.sv
// ----------------------------------------------------------------------------
// xsr_pkg
// Types and constants shared by the xoshiro256** random draw block.
// ----------------------------------------------------------------------------
package xsr_pkg;

	localparam int WORD_W     = 64;
	localparam int FRAC_W     = 52;
	localparam int FRAC_SHIFT = 12;
	localparam int NUM_WORDS  = 4;
	localparam int IDX_W      = 2;
	localparam int CNT_W      = 6;

	// xoshiro256** shift and rotate amounts
	localparam int SCR_ROT = 7;
	localparam int W1_SHL  = 17;
	localparam int W3_ROT  = 45;

	localparam logic [WORD_W-1:0] SEED0_RST = 64'd1;

	typedef enum logic [1:0] {
		CMD_UNIT    = 2'd0,
		CMD_BOUNDED = 2'd1,
		CMD_RELOAD  = 2'd2
	} cmd_e;

	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_BAD_RANGE = 1'b1;

	typedef struct packed {
		logic [1:0]               command;
		logic signed [WORD_W-1:0] lower_bound;
		logic signed [WORD_W-1:0] upper_bound;
	} in_item_t;

	typedef struct packed {
		logic [FRAC_W-1:0]        fraction;
		logic signed [WORD_W-1:0] bounded_value;
		logic                     status;
	} out_item_t;

	typedef struct packed {
		logic advance;
		logic reload;
	} gen_ctl_t;

	function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int amt);
		logic [2*WORD_W-1:0] dbl;
		dbl = {v, v} << amt;
		return dbl[2*WORD_W-1 -: WORD_W];
	endfunction

endpackage

FILE: rtl/xoshiro256ss_random_draw_top.sv
// ----------------------------------------------------------------------------
// xoshiro256ss_random_draw_top
// xoshiro256** generator answering unit, bounded and reload commands.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid/in_ready/in_data): one command item at a time; the
//     block takes a new item once the previous one has reached the output
//     register, even while that result is still waiting to be taken.
//   out channel (out_valid/out_ready/out_data): exactly one result item per
//     command item, in order.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): writes seed word
//     cfg_index; always ready. Seeds take effect on the next reload command.
// Path from accept to out_valid:
//   reload, unused code, reversed bounds: decode, then output register
//   unit draw: decode, two-stage scrambler, output register
//   bounded draw: decode, scrambler, bit-serial remainder unit, add, output;
//   a full 64-bit span skips the divider.
// Reset loads seeds and generator with 1,0,0,0 and empties the output.
// If the receiver stalls, the result holds in the output register and a
// finished next result waits in the sequencer until the register frees up.
// ----------------------------------------------------------------------------
module xoshiro256ss_random_draw_top import xsr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [WORD_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_MUL,
		S_DIV,
		S_ADD,
		S_OUT
	} state_t;

	state_t            state_q;
	in_item_t          item_q;
	out_item_t         res_q, out_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] span_q, acc_q;

	gen_ctl_t          ctl;
	logic [WORD_W-1:0] w1, draw, rem, span;
	logic              mul_start, mul_done, div_start, div_done, bad_range;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// signed compare by flipping the sign bits
	assign bad_range = {~item_q.lower_bound[WORD_W-1], item_q.lower_bound[WORD_W-2:0]} >
		{~item_q.upper_bound[WORD_W-1], item_q.upper_bound[WORD_W-2:0]};
	assign span = item_q.upper_bound - item_q.lower_bound + 1'b1;

	always_comb begin
		mul_start   = 1'b0;
		ctl.advance = 1'b0;
		ctl.reload  = 1'b0;
		if (state_q == S_DECODE) begin
			if (item_q.command == CMD_UNIT ||
				(item_q.command == CMD_BOUNDED && !bad_range)) begin
				mul_start   = 1'b1;
				ctl.advance = 1'b1;
			end
			ctl.reload = (item_q.command == CMD_RELOAD);
		end
		div_start = (state_q == S_MUL) && mul_done &&
			(item_q.command == CMD_BOUNDED) && (span_q != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			item_q      <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			span_q      <= '0;
			acc_q       <= '0;
		end else begin
			if (state_q == S_OUT && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						item_q  <= in_data;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					span_q <= span;
					unique case (item_q.command)
						CMD_UNIT: begin
							res_q   <= '0;
							state_q <= S_MUL;
						end
						CMD_BOUNDED: begin
							if (bad_range) begin
								res_q   <= '{fraction: '0, bounded_value: '0,
									status: STATUS_BAD_RANGE};
								state_q <= S_OUT;
							end else begin
								res_q   <= '0;
								state_q <= S_MUL;
							end
						end
						default: begin
							res_q   <= '0;
							state_q <= S_OUT;
						end
					endcase
				end
				S_MUL: begin
					if (mul_done) begin
						if (item_q.command == CMD_UNIT) begin
							res_q.fraction <= draw[WORD_W-1:FRAC_SHIFT];
							state_q        <= S_OUT;
						end else if (span_q == '0) begin
							// full 64-bit span: no reduction
							acc_q   <= draw;
							state_q <= S_ADD;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						acc_q   <= rem;
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					res_q.bounded_value <= acc_q + item_q.lower_bound;
					state_q             <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	xsr_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.ctl       (ctl),
		.w1        (w1)
	);

	xsr_scramble u_scramble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.w1     (w1),
		.done   (mul_done),
		.draw   (draw)
	);

	xsr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (draw),
		.divisor   (span_q),
		.done      (div_done),
		.remainder (rem)
	);

endmodule

FILE: rtl/xsr_state.sv
// ----------------------------------------------------------------------------
// xsr_state
// Seed registers and the four generator words with the xoshiro256 update.
// ----------------------------------------------------------------------------
module xsr_state import xsr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_idx,
	input  logic [WORD_W-1:0] cfg_wdata,
	input  gen_ctl_t          ctl,
	output logic [WORD_W-1:0] w1
);

	logic [WORD_W-1:0] seed_q [NUM_WORDS];
	logic [WORD_W-1:0] w_q [NUM_WORDS];
	logic [WORD_W-1:0] n0, n1, n2, n3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q[0] <= SEED0_RST;
			seed_q[1] <= '0;
			seed_q[2] <= '0;
			seed_q[3] <= '0;
		end else if (cfg_we) begin
			seed_q[cfg_idx] <= cfg_wdata;
		end
	end

	always_comb begin
		n2 = w_q[2] ^ w_q[0];
		n3 = w_q[3] ^ w_q[1];
		n1 = w_q[1] ^ n2;
		n0 = w_q[0] ^ n3;
		n2 = n2 ^ (w_q[1] << W1_SHL);
		n3 = rotl(n3, W3_ROT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q[0] <= SEED0_RST;
			w_q[1] <= '0;
			w_q[2] <= '0;
			w_q[3] <= '0;
		end else if (ctl.reload) begin
			w_q[0] <= seed_q[0];
			w_q[1] <= seed_q[1];
			w_q[2] <= seed_q[2];
			w_q[3] <= seed_q[3];
		end else if (ctl.advance) begin
			w_q[0] <= n0;
			w_q[1] <= n1;
			w_q[2] <= n2;
			w_q[3] <= n3;
		end
	end

	assign w1 = w_q[1];

endmodule

FILE: rtl/xsr_scramble.sv
// ----------------------------------------------------------------------------
// xsr_scramble
// Output scrambler: rotl(w1 * 5, 7) * 9 over two register stages.
// ----------------------------------------------------------------------------
module xsr_scramble import xsr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] w1,
	output logic              done,
	output logic [WORD_W-1:0] draw
);

	logic              v_s1, v_s2;
	logic [WORD_W-1:0] p_s1, d_s2, r;

	assign r = rotl(p_s1, SCR_ROT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
		end
	end

	// x*5 = (x<<2)+x, x*9 = (x<<3)+x
	always_ff @(posedge clk) begin
		if (start) p_s1 <= (w1 << 2) + w1;
		if (v_s1) d_s2 <= (r << 3) + r;
	end

	assign done = v_s2;
	assign draw = d_s2;

endmodule

FILE: rtl/xsr_div.sv
// ----------------------------------------------------------------------------
// xsr_div
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module xsr_div import xsr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] dividend,
	input  logic [WORD_W-1:0] divisor,
	output logic              done,
	output logic [WORD_W-1:0] remainder
);

	logic              busy_q, done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WORD_W-1:0] rem_q, quo_q, dvs_q;
	logic [WORD_W:0]   trial, diff;

	assign trial = {rem_q, quo_q[WORD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (&cnt_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			// borrow out of the trial subtract means keep the shifted remainder
			rem_q <= diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
			quo_q <= quo_q << 1;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

FILE: rtl/xsr_checker.sv
// ----------------------------------------------------------------------------
// xsr_checker
// Port-level checks for the random draw block, bound to the top level.
// ----------------------------------------------------------------------------
module xsr_checker import xsr_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input in_item_t          in_data,
	input logic              out_valid,
	input logic              out_ready,
	input out_item_t         out_data,
	input logic              cfg_valid,
	input logic              cfg_ready,
	input logic [IDX_W-1:0]  cfg_index,
	input logic [WORD_W-1:0] cfg_data
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// one item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while busy");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == STATUS_BAD_RANGE |->
		out_data.fraction == '0 && out_data.bounded_value == '0)
		else $error("error result carries data");

	a_frac_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.fraction != '0 |->
		out_data.bounded_value == '0 && out_data.status == STATUS_OK)
		else $error("unit draw result mixes fields");

	a_cfg_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("seed write stalled");

endmodule

bind xoshiro256ss_random_draw_top xsr_checker u_xsr_checker (.*);
